### sv/bocv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bocv_pkg
// Shared types and constants of the battery voltage to capacity lookup.
// ----------------------------------------------------------------------------
package bocv_pkg;

  localparam int TABLES_DEF = 16;
  localparam int POINTS_DEF = 32;

  localparam int VOLT_W = 23;
  localparam int CAP_W  = 8;
  localparam int TEMP_W = 8;
  localparam int LEN_W  = 6;
  localparam int TIU_W  = 5;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_TABLE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_TABLE = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;

  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic [CAP_W-1:0]  cap;
  } point_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [LEN_W-1:0]         len;
  } tab_entry_t;

endpackage
`default_nettype wire

### sv/battery_ocv_to_capacity_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_ocv_to_capacity_core
// Open-circuit-voltage to capacity lookup over temperature tables.
//
// Items arrive on the in_* channel and are transferred when in_valid is high
// and in_stall is low. A query gives one result on the out_* channel,
// transferred when out_valid is high and out_stall is low; loads give none and
// are taken back to back while no query is in progress. The cfg_* channel
// writes the number of tables in use; it is always ready.
// A query scans the tables in use for the one nearest the query temperature,
// then its points up to the first one below the query voltage, as both
// memories are walked one entry per cycle. An interpolation takes a multiply,
// eight divide steps at one quotient bit each and an adjust. With no table
// in use the query skips both scans; with an empty table it skips the point
// scan.
// A finished result waits in the output register while the next item is
// taken; a later query holds at its end until that register is free.
// Reset clears out_valid and the table valid flags, by which an unwritten
// table reads as temperature and length zero; table and point storage keep no reset value.
// ----------------------------------------------------------------------------
module battery_ocv_to_capacity_core #(
  parameter int TABLES = bocv_pkg::TABLES_DEF,
  parameter int POINTS = bocv_pkg::POINTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [bocv_pkg::TIU_W-1:0]         cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [1:0]                         kind,
  input  wire  [3:0]                         table_index,
  input  wire  [4:0]                         point_index,
  input  wire  [bocv_pkg::VOLT_W-1:0]        point_voltage,
  input  wire  [bocv_pkg::CAP_W-1:0]         point_capacity,
  input  wire  signed [bocv_pkg::TEMP_W-1:0] table_temperature,
  input  wire  [bocv_pkg::LEN_W-1:0]         table_length,
  input  wire  [bocv_pkg::VOLT_W-1:0]        query_voltage,
  input  wire  signed [bocv_pkg::TEMP_W-1:0] query_temperature,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [bocv_pkg::CAP_W-1:0]         capacity,
  output logic [1:0]                         status
);
  import bocv_pkg::*;

  localparam int TIW   = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int CW    = $clog2(TABLES + 1);
  localparam int PIW   = $clog2(POINTS);
  localparam int LW    = $clog2(POINTS + 1);
  localparam int DEPTH = TABLES * POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NUM_W = CAP_W + VOLT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TSCAN  = 3'd1;
  localparam logic [2:0] S_PSETUP = 3'd2;
  localparam logic [2:0] S_PSCAN  = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_ADJ    = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  tab_entry_t tmem [TABLES];
  point_t     pmem [DEPTH];
  logic [TABLES-1:0] tvalid;

  logic [2:0]              state;
  logic [TIU_W-1:0]        tiu;
  logic [VOLT_W-1:0]       qvolt;
  logic signed [TEMP_W-1:0] qtemp;
  logic [CW-1:0]           used;
  logic [CW-1:0]           tcnt;
  logic                    tpend;
  logic [TIW-1:0]          tidx;
  logic [TIW-1:0]          best;
  logic [TEMP_W:0]         best_diff;
  logic [LEN_W-1:0]        best_len;
  tab_entry_t              tq;
  logic                    tq_ok;
  logic [AW-1:0]           base;
  logic [LW-1:0]           plen;
  logic [LW-1:0]           pcnt;
  logic                    ppend;
  logic [PIW-1:0]          pidx;
  point_t                  pq;
  point_t                  prev;
  point_t                  cur;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        dsh;
  logic [CAP_W-1:0]        quo;
  logic                    neg;
  logic [2:0]              dstep;
  logic [CAP_W-1:0]        res_cap;
  logic [1:0]              res_status;

  logic                    in_xfer;
  logic                    out_free;
  logic                    out_load;
  logic                    t_we;
  logic                    t_re;
  logic                    p_we;
  logic                    p_re;
  logic [AW-1:0]           p_waddr;
  logic [AW-1:0]           p_raddr;
  logic [5:0]              used_calc;
  logic signed [TEMP_W-1:0] t_temp;
  logic [LEN_W-1:0]        t_len;
  logic signed [TEMP_W:0]  t_sdiff;
  logic [TEMP_W:0]         t_diff;
  logic [LW-1:0]           len_calc;
  logic signed [CAP_W:0]   dcap;
  logic [CAP_W-1:0]        dmag;
  logic [VOLT_W-1:0]       dvolt;
  logic [VOLT_W-1:0]       den;
  logic [NUM_W-1:0]        prod;
  logic signed [CAP_W+1:0] adj;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_FINISH) && out_free;

  always_comb begin
    used_calc = ({1'b0, tiu} > 6'(TABLES)) ? 6'(TABLES) : {1'b0, tiu};
    t_we      = in_xfer && (kind == KIND_TABLE) && (int'(table_index) < TABLES);
    p_we      = in_xfer && (kind == KIND_POINT) && (int'(table_index) < TABLES)
                && (int'(point_index) < POINTS);
    p_waddr   = AW'(int'(table_index) * POINTS + int'(point_index));
    t_re      = (state == S_TSCAN) && (tcnt < used);
    p_re      = (state == S_PSCAN) && (pcnt < plen);
    p_raddr   = AW'(int'(base) + int'(pcnt));
    t_temp    = tq_ok ? tq.temp : '0;
    t_len     = tq_ok ? tq.len : '0;
    t_sdiff   = {t_temp[TEMP_W-1], t_temp} - {qtemp[TEMP_W-1], qtemp};
    t_diff    = t_sdiff[TEMP_W] ? (TEMP_W+1)'(-t_sdiff) : t_sdiff;
    len_calc  = (int'(best_len) > POINTS) ? LW'(POINTS) : LW'(best_len);
    dcap      = {1'b0, prev.cap} - {1'b0, cur.cap};
    dmag      = dcap[CAP_W] ? CAP_W'(-dcap) : dcap[CAP_W-1:0];
    dvolt     = qvolt - cur.volt;
    den       = prev.volt - cur.volt;
    prod      = NUM_W'(dmag) * NUM_W'(dvolt);
    adj       = neg ? ({2'b00, cur.cap} - {2'b00, quo}) : ({2'b00, cur.cap} + {2'b00, quo});
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[TIW'(table_index)] <= '{temp: table_temperature, len: table_length};
    end
    if (t_re) begin
      tq <= tmem[tcnt[TIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= '{volt: point_voltage, cap: point_capacity};
    end
    if (p_re) begin
      pq <= pmem[p_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tiu       <= '0;
      tvalid    <= '0;
      out_valid <= 1'b0;
      tpend     <= 1'b0;
      ppend     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tiu <= cfg_data;
      end
      if (t_we) begin
        tvalid[TIW'(table_index)] <= 1'b1;
      end
      if (t_re) begin
        tq_ok <= tvalid[tcnt[TIW-1:0]];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer && (kind == KIND_QUERY)) begin
            qvolt     <= query_voltage;
            qtemp     <= query_temperature;
            used      <= CW'(used_calc);
            tcnt      <= '0;
            tpend     <= 1'b0;
            best      <= '0;
            best_diff <= '1;
            best_len  <= '0;
            if (used_calc == 6'd0) begin
              res_cap    <= '0;
              res_status <= STAT_NO_TABLE;
              state      <= S_FINISH;
            end else begin
              state <= S_TSCAN;
            end
          end
        end

        S_TSCAN: begin
          if (t_re) begin
            tcnt  <= tcnt + 1'b1;
            tidx  <= tcnt[TIW-1:0];
            tpend <= 1'b1;
          end else begin
            tpend <= 1'b0;
          end
          if (tpend) begin
            if (t_diff < best_diff) begin
              best_diff <= t_diff;
              best      <= tidx;
              best_len  <= t_len;
            end
          end else if (tcnt == used) begin
            state <= S_PSETUP;
          end
        end

        S_PSETUP: begin
          base  <= AW'(int'(best) * POINTS);
          plen  <= len_calc;
          pcnt  <= '0;
          ppend <= 1'b0;
          if (len_calc == '0) begin
            res_cap    <= '0;
            res_status <= STAT_EMPTY;
            state      <= S_FINISH;
          end else begin
            state <= S_PSCAN;
          end
        end

        S_PSCAN: begin
          if (p_re) begin
            pcnt  <= pcnt + 1'b1;
            pidx  <= pcnt[PIW-1:0];
            ppend <= 1'b1;
          end else begin
            ppend <= 1'b0;
          end
          if (ppend) begin
            if (qvolt > pq.volt) begin
              if (pidx == '0) begin
                res_cap    <= pq.cap;
                res_status <= STAT_OK;
                state      <= S_FINISH;
              end else begin
                cur   <= pq;
                state <= S_MUL;
              end
            end else begin
              prev <= pq;
            end
          end else if (pcnt == plen) begin
            res_cap    <= prev.cap;
            res_status <= STAT_OK;
            state      <= S_FINISH;
          end
        end

        S_MUL: begin
          if (den == '0) begin
            res_cap    <= cur.cap;
            res_status <= STAT_OK;
            state      <= S_FINISH;
          end else begin
            num   <= prod;
            dsh   <= {1'b0, den, 7'd0};
            neg   <= dcap[CAP_W];
            quo   <= '0;
            dstep <= '0;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (num >= dsh) begin
            num <= num - dsh;
            quo <= {quo[CAP_W-2:0], 1'b1};
          end else begin
            quo <= {quo[CAP_W-2:0], 1'b0};
          end
          dsh   <= dsh >> 1;
          dstep <= dstep + 1'b1;
          if (dstep == 3'd7) begin
            state <= S_ADJ;
          end
        end

        S_ADJ: begin
          if (adj[CAP_W+1]) begin
            res_cap <= '0;
          end else if (adj[CAP_W]) begin
            res_cap <= '1;
          end else begin
            res_cap <= adj[CAP_W-1:0];
          end
          res_status <= STAT_OK;
          state      <= S_FINISH;
        end

        S_FINISH: begin
          if (out_load) begin
            capacity <= res_cap;
            status   <= res_status;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
